// ===== sv/eab_pkg.sv =====
// ----------------------------------------------------------------------------
// eab_pkg: shared types, constants and functions
// Fixed-point formats, series coefficients and output rounding for the
// Euler angle to basis vector pipeline.
// ----------------------------------------------------------------------------
package eab_pkg;

   // Angle width used from each 16-bit input field, and output fraction bits
   localparam int ANGLE_BITS = 16;
   localparam int FRAC_BITS  = 14;
   localparam int FIELD_BITS = 16;
   localparam int OUT_BITS   = 16;

   // Internal Q30 working format
   localparam int WORK_BITS = 30;
   localparam logic [30:0] WORK_ONE  = 31'd1 << WORK_BITS;
   localparam logic [63:0] WORK_HALF = 64'd1 << (WORK_BITS - 1);

   // pi/2 in Q30
   localparam logic [30:0] PI_HALF = 31'd1686629713;

   // Angle folding
   localparam logic [ANGLE_BITS-2:0] QUARTER_R = (ANGLE_BITS - 1)'(1) << (ANGLE_BITS - 2);
   localparam logic [ANGLE_BITS-1:0] QUARTER   = ANGLE_BITS'(1) << (ANGLE_BITS - 2);
   localparam int UP_SHIFT = WORK_BITS - (ANGLE_BITS - 2);

   // Horner series: one cell per term, three stages per cell
   localparam int HORNER_STEPS = 7;
   localparam int CELL_STAGES  = 3;
   // Term factors 2k(2k+1), k = 7 down to 1, and floor(2^32 / factor)
   localparam logic [7:0]  HORNER_DIV   [HORNER_STEPS] = '{8'd210, 8'd156, 8'd110, 8'd72,
                                                           8'd42, 8'd20, 8'd6};
   localparam logic [29:0] HORNER_RECIP [HORNER_STEPS] = '{30'd20452225, 30'd27531841,
                                                           30'd39045157, 30'd59652323,
                                                           30'd102261126, 30'd214748364,
                                                           30'd715827882};

   // Pipeline depths
   localparam int SINE_LATENCY = 2 + HORNER_STEPS * CELL_STAGES + 1;
   localparam int QMUL_LATENCY = 2;
   localparam int LATENCY      = SINE_LATENCY + 2 * QMUL_LATENCY + 2;

   // Output rounding
   localparam int OUT_SHIFT = WORK_BITS - FRAC_BITS;
   localparam logic [32:0] OUT_RND = (OUT_SHIFT > 0) ? (33'd1 << (OUT_SHIFT - 1)) : 33'd0;
   localparam logic [32:0] OUT_LIM = 33'd1 << FRAC_BITS;
   localparam logic signed [OUT_BITS-1:0] RESULT_LIM = OUT_BITS'(1 << FRAC_BITS);

   typedef logic [ANGLE_BITS-1:0]   angle_type;
   typedef logic signed [31:0]      work_type;
   typedef logic signed [32:0]      sum_type;
   typedef logic [OUT_BITS-1:0]     result_type;

   // Data handed from cell to cell beside the running series term
   typedef struct packed {
      logic [30:0] x;
      logic [31:0] s;
      logic        neg;
   } horner_side_type;

   // Round a Q30 sum on its magnitude, saturate to +-1.0, fold into the field
   function automatic result_type to_out(input sum_type v);
      logic [32:0] mag;
      logic [32:0] m;
      logic [32:0] r;
      mag = v[32] ? 33'(-v) : 33'(v);
      m   = (mag + OUT_RND) >> OUT_SHIFT;
      if (m > OUT_LIM) begin
         m = OUT_LIM;
      end
      r = v[32] ? 33'(-m) : m;
      return r[OUT_BITS-1:0];
   endfunction

endpackage

// ===== sv/eab_cell.sv =====
// ----------------------------------------------------------------------------
// eab_cell: one Horner step of the sine series
// Computes t' = 1 - round(s*t) / factor over three stages and hands x, s and
// the sign along to the next cell.
// ----------------------------------------------------------------------------
module eab_cell (
   input  logic                     clock,
   input  eab_pkg::horner_side_type side_in,
   input  logic [30:0]              t_in,
   input  logic [7:0]               divisor,
   input  logic [29:0]              recip,
   output eab_pkg::horner_side_type side_out,
   output logic [30:0]              t_out
);

   eab_pkg::horner_side_type side_a_ff, side_b_ff, side_c_ff;
   logic [31:0] q_a_ff, q_b_ff;
   logic [31:0] q_a_in;
   logic [63:0] prod_a;
   logic [63:0] qr_ff, qr_in;
   logic [31:0] q_est;
   logic [39:0] est_d;
   logic [39:0] rem;
   logic [31:0] p;
   logic [30:0] t_ff, t_in_c;

   // Stage A: rounded Q30 product of s and t
   assign prod_a = 64'(side_in.s) * 64'(t_in) + eab_pkg::WORK_HALF;
   assign q_a_in = prod_a[61:30];

   // Stage B: multiply by the reciprocal of the term factor
   assign qr_in = 64'(q_a_ff) * 64'(recip);

   // Stage C: correct the estimated quotient and form 1 - p
   assign q_est  = qr_ff[63:32];
   assign est_d  = 40'(q_est) * 40'(divisor);
   assign rem    = 40'(q_b_ff) - est_d;
   assign p      = q_est + 32'(rem >= 40'(divisor));
   assign t_in_c = (p >= 32'(eab_pkg::WORK_ONE)) ? 31'd0 : 31'(32'(eab_pkg::WORK_ONE) - p);

   // Advance the item through the three stages
   always_ff @(posedge clock) begin
      side_a_ff <= side_in;
      q_a_ff    <= q_a_in;
      side_b_ff <= side_a_ff;
      q_b_ff    <= q_a_ff;
      qr_ff     <= qr_in;
      side_c_ff <= side_b_ff;
      t_ff      <= t_in_c;
   end

   assign side_out = side_c_ff;
   assign t_out    = t_ff;

endmodule

// ===== sv/eab_sine.sv =====
// ----------------------------------------------------------------------------
// eab_sine: pipelined sine of a binary angle
// Folds the angle into the first quadrant, scales it to radians, runs the
// Horner series through a row of cells and clamps the result to +-1.0 (Q30).
// ----------------------------------------------------------------------------
module eab_sine (
   input  logic                clock,
   input  eab_pkg::angle_type  angle,
   output eab_pkg::work_type   sine
);

   localparam int AB = eab_pkg::ANGLE_BITS;

   logic [1:0]    quad;
   logic [AB-2:0] r_raw, r_fold;
   logic [30:0]   u;
   logic [63:0]   x_prod;
   logic [30:0]   x1_ff;
   logic          neg1_ff;
   logic [63:0]   s_prod;
   eab_pkg::horner_side_type side_ff, side_in;
   eab_pkg::horner_side_type side_chain [eab_pkg::HORNER_STEPS+1];
   logic [30:0]   t_chain [eab_pkg::HORNER_STEPS+1];
   logic [63:0]   m_prod;
   logic [31:0]   m_raw, m_clamp;
   eab_pkg::work_type sine_ff, sine_in;

   // Fold into the first quadrant and scale to radians
   assign quad   = angle[AB-1:AB-2];
   assign r_raw  = {1'b0, angle[AB-3:0]};
   assign r_fold = quad[0] ? (eab_pkg::QUARTER_R - r_raw) : r_raw;
   assign u      = {r_fold, {eab_pkg::UP_SHIFT{1'b0}}};
   assign x_prod = 64'(u) * 64'(eab_pkg::PI_HALF) + eab_pkg::WORK_HALF;

   // Square of x feeds every series cell
   assign s_prod       = 64'(x1_ff) * 64'(x1_ff) + eab_pkg::WORK_HALF;
   assign side_in.x    = x1_ff;
   assign side_in.s    = s_prod[61:30];
   assign side_in.neg  = neg1_ff;

   always_ff @(posedge clock) begin
      x1_ff   <= x_prod[60:30];
      neg1_ff <= quad[1];
      side_ff <= side_in;
   end

   assign side_chain[0] = side_ff;
   assign t_chain[0]    = eab_pkg::WORK_ONE;

   // Row of Horner cells
   for (genvar g = 0; g < eab_pkg::HORNER_STEPS; g++) begin : g_cell
      eab_cell u_cell (
         .clock    (clock),
         .side_in  (side_chain[g]),
         .t_in     (t_chain[g]),
         .divisor  (eab_pkg::HORNER_DIV[g]),
         .recip    (eab_pkg::HORNER_RECIP[g]),
         .side_out (side_chain[g+1]),
         .t_out    (t_chain[g+1])
      );
   end

   // Final multiply by x, clamp and apply the half-turn sign
   assign m_prod  = 64'(side_chain[eab_pkg::HORNER_STEPS].x) *
                    64'(t_chain[eab_pkg::HORNER_STEPS]) + eab_pkg::WORK_HALF;
   assign m_raw   = m_prod[61:30];
   assign m_clamp = (m_raw > 32'(eab_pkg::WORK_ONE)) ? 32'(eab_pkg::WORK_ONE) : m_raw;
   assign sine_in = side_chain[eab_pkg::HORNER_STEPS].neg ? -$signed(m_clamp)
                                                         : $signed(m_clamp);

   always_ff @(posedge clock) begin
      sine_ff <= sine_in;
   end

   assign sine = sine_ff;

endmodule

// ===== sv/eab_qmul.sv =====
// ----------------------------------------------------------------------------
// eab_qmul: signed Q30 multiply
// Multiplies magnitudes, rounds to nearest with ties away from zero and
// restores the sign; two stages.
// ----------------------------------------------------------------------------
module eab_qmul (
   input  logic              clock,
   input  eab_pkg::work_type a,
   input  eab_pkg::work_type b,
   output eab_pkg::work_type p
);

   logic [31:0] mag_a, mag_b;
   logic [63:0] raw_ff, raw_in;
   logic        neg_ff;
   logic [63:0] rnd;
   eab_pkg::work_type p_ff, p_in;

   // Stage 1: product of magnitudes
   assign mag_a  = a[31] ? 32'(-a) : 32'(a);
   assign mag_b  = b[31] ? 32'(-b) : 32'(b);
   assign raw_in = 64'(mag_a) * 64'(mag_b);

   // Stage 2: round and restore the sign
   assign rnd  = raw_ff + eab_pkg::WORK_HALF;
   assign p_in = neg_ff ? -$signed(rnd[61:30]) : $signed(rnd[61:30]);

   always_ff @(posedge clock) begin
      raw_ff <= raw_in;
      neg_ff <= a[31] ^ b[31];
      p_ff   <= p_in;
   end

   assign p = p_ff;

endmodule

// ===== sv/euler_angles_to_basis_vectors.sv =====
// ----------------------------------------------------------------------------
// euler_angles_to_basis_vectors: yaw-pitch-roll angles to rotation basis
// Takes pitch, yaw and roll as binary angles and returns the right, up and
// negated forward unit vectors as signed Q1.14 components.
// ----------------------------------------------------------------------------
//
//  channel   ports                          handshake
//  -------   -----------------------------  ------------------------------
//  request   req_pitch/yaw/roll_angle       start high, busy low
//  response  rsp_right_*, rsp_up_*, rsp_fwd_*  rsp_valid, one cycle
//
// A new item is taken every cycle; busy stays low.
// Each result passes through the 7-cell Horner row of the sine units
// (3 stages a cell), then two product levels and rounding.
// Reset clears the valid pipeline only; no item is in flight after it.
// The receiver cannot stall: results leave on the cycle rsp_valid is high.
//
module euler_angles_to_basis_vectors (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [15:0] req_pitch_angle,
   input  logic [15:0] req_yaw_angle,
   input  logic [15:0] req_roll_angle,
   output logic        rsp_valid,
   output logic signed [15:0] rsp_right_x,
   output logic signed [15:0] rsp_right_y,
   output logic signed [15:0] rsp_right_z,
   output logic signed [15:0] rsp_up_x,
   output logic signed [15:0] rsp_up_y,
   output logic signed [15:0] rsp_up_z,
   output logic signed [15:0] rsp_fwd_x,
   output logic signed [15:0] rsp_fwd_y,
   output logic signed [15:0] rsp_fwd_z
);

   localparam int AB  = eab_pkg::ANGLE_BITS;
   localparam int LAT = eab_pkg::LATENCY;

   logic accept;
   logic [LAT-1:0] valid_ff, valid_in;
   eab_pkg::angle_type pitch, yaw, roll;
   eab_pkg::work_type sp, cp, sh, ch, sb, cb;

   // Level 1 products: shsp chsp chcb sbcp shcb chsb cbcp sbsh shcp chcp
   eab_pkg::work_type l1 [10];
   eab_pkg::work_type l1_d1_ff [10];
   eab_pkg::work_type l1_d2_ff [10];
   eab_pkg::work_type sb_d1_ff, sb_d2_ff, cb_d1_ff, cb_d2_ff;
   eab_pkg::work_type sp_d_ff [2*eab_pkg::QMUL_LATENCY];
   eab_pkg::work_type t_shsp_sb, t_chsp_sb, t_shsp_cb, t_chsp_cb;
   eab_pkg::sum_type  sum_ff [9];
   eab_pkg::sum_type  sum_in [9];
   eab_pkg::result_type out_ff [9];

   assign busy   = 1'b0;
   assign accept = start & ~busy;

   // Use the low angle bits; bits above the field read as zero
   always_comb begin
      pitch = eab_pkg::angle_type'({{AB{1'b0}}, req_pitch_angle});
      yaw   = eab_pkg::angle_type'({{AB{1'b0}}, req_yaw_angle});
      roll  = eab_pkg::angle_type'({{AB{1'b0}}, req_roll_angle});
   end

   // Sine and cosine units
   eab_sine u_sp (.clock(clock), .angle(pitch), .sine(sp));
   eab_sine u_cp (.clock(clock), .angle(eab_pkg::angle_type'(pitch + eab_pkg::QUARTER)),
                  .sine(cp));
   eab_sine u_sh (.clock(clock), .angle(yaw), .sine(sh));
   eab_sine u_ch (.clock(clock), .angle(eab_pkg::angle_type'(yaw + eab_pkg::QUARTER)),
                  .sine(ch));
   eab_sine u_sb (.clock(clock), .angle(roll), .sine(sb));
   eab_sine u_cb (.clock(clock), .angle(eab_pkg::angle_type'(roll + eab_pkg::QUARTER)),
                  .sine(cb));

   // Pair products
   eab_qmul u_m0 (.clock(clock), .a(sh), .b(sp), .p(l1[0]));
   eab_qmul u_m1 (.clock(clock), .a(ch), .b(sp), .p(l1[1]));
   eab_qmul u_m2 (.clock(clock), .a(ch), .b(cb), .p(l1[2]));
   eab_qmul u_m3 (.clock(clock), .a(sb), .b(cp), .p(l1[3]));
   eab_qmul u_m4 (.clock(clock), .a(sh), .b(cb), .p(l1[4]));
   eab_qmul u_m5 (.clock(clock), .a(ch), .b(sb), .p(l1[5]));
   eab_qmul u_m6 (.clock(clock), .a(cb), .b(cp), .p(l1[6]));
   eab_qmul u_m7 (.clock(clock), .a(sb), .b(sh), .p(l1[7]));
   eab_qmul u_m8 (.clock(clock), .a(sh), .b(cp), .p(l1[8]));
   eab_qmul u_m9 (.clock(clock), .a(ch), .b(cp), .p(l1[9]));

   // Triple products on the held roll terms
   eab_qmul u_t0 (.clock(clock), .a(l1[0]), .b(sb_d2_ff), .p(t_shsp_sb));
   eab_qmul u_t1 (.clock(clock), .a(l1[1]), .b(sb_d2_ff), .p(t_chsp_sb));
   eab_qmul u_t2 (.clock(clock), .a(l1[0]), .b(cb_d2_ff), .p(t_shsp_cb));
   eab_qmul u_t3 (.clock(clock), .a(l1[1]), .b(cb_d2_ff), .p(t_chsp_cb));

   // Align operands with the product levels
   always_ff @(posedge clock) begin
      sb_d1_ff <= sb;
      sb_d2_ff <= sb_d1_ff;
      cb_d1_ff <= cb;
      cb_d2_ff <= cb_d1_ff;
      sp_d_ff[0] <= sp;
      for (int i = 1; i < 2*eab_pkg::QMUL_LATENCY; i++) begin
         sp_d_ff[i] <= sp_d_ff[i-1];
      end
      for (int i = 0; i < 10; i++) begin
         l1_d1_ff[i] <= l1[i];
         l1_d2_ff[i] <= l1_d1_ff[i];
      end
   end

   // Sum the terms of each component
   always_comb begin
      sum_in[0] = 33'(l1_d2_ff[2]) + 33'(t_shsp_sb);
      sum_in[1] = 33'(l1_d2_ff[3]);
      sum_in[2] = 33'(t_chsp_sb) - 33'(l1_d2_ff[4]);
      sum_in[3] = 33'(t_shsp_cb) - 33'(l1_d2_ff[5]);
      sum_in[4] = 33'(l1_d2_ff[6]);
      sum_in[5] = 33'(l1_d2_ff[7]) + 33'(t_chsp_cb);
      sum_in[6] = -33'(l1_d2_ff[8]);
      sum_in[7] = 33'(sp_d_ff[2*eab_pkg::QMUL_LATENCY-1]);
      sum_in[8] = -33'(l1_d2_ff[9]);
   end

   // Register sums, then round and saturate
   always_ff @(posedge clock) begin
      for (int i = 0; i < 9; i++) begin
         sum_ff[i] <= sum_in[i];
         out_ff[i] <= eab_pkg::to_out(sum_ff[i]);
      end
   end

   // Track items through the pipeline
   assign valid_in = {valid_ff[LAT-2:0], accept};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign rsp_valid   = valid_ff[LAT-1];
   assign rsp_right_x = out_ff[0];
   assign rsp_right_y = out_ff[1];
   assign rsp_right_z = out_ff[2];
   assign rsp_up_x    = out_ff[3];
   assign rsp_up_y    = out_ff[4];
   assign rsp_up_z    = out_ff[5];
   assign rsp_fwd_x   = out_ff[6];
   assign rsp_fwd_y   = out_ff[7];
   assign rsp_fwd_z   = out_ff[8];

   // The y components stay within the unit range
   a_fwd_y_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_fwd_y <= eab_pkg::RESULT_LIM && rsp_fwd_y >= -eab_pkg::RESULT_LIM))
      else $error("fwd_y out of unit range");

   a_right_y_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_right_y <= eab_pkg::RESULT_LIM &&
                     rsp_right_y >= -eab_pkg::RESULT_LIM))
      else $error("right_y out of unit range");

   a_up_y_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_up_y <= eab_pkg::RESULT_LIM && rsp_up_y >= -eab_pkg::RESULT_LIM))
      else $error("up_y out of unit range");

endmodule
